// ===== hdl/cpts_pkg.sv =====
// Shared types and constants for the counter/priority task scheduler.
// Used by cpts_slot_mem and counter_priority_task_scheduler; no dependencies.
package cpts_pkg;

	localparam int NUM_SLOTS = 64;
	localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);
	localparam logic [SLOT_W-1:0] FIRST_SLOT = SLOT_W'(1);

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_SCHED = 1'b1;

	localparam logic [1:0] RS_RUN  = 2'd0;
	localparam logic [1:0] RS_INTR = 2'd1;

	// alarm is signal 14, kill 9 and stop 19 can never be blocked
	localparam logic [31:0] SIG_ALARM_BIT = 32'h0000_2000;
	localparam logic [31:0] UNBLOCKABLE   = 32'h0004_0100;

	localparam logic [6:0] COUNTER_MAX = 7'd127;

	typedef struct packed {
		logic [1:0]  run_state;
		logic [6:0]  counter;
		logic [5:0]  prio;
		logic [31:0] alarm;
		logic [31:0] pending;
		logic [31:0] blocked;
	} entry_t;

	typedef struct packed {
		logic              rd_en;
		logic [SLOT_W-1:0] rd_addr;
		logic              wr_en;
		logic [SLOT_W-1:0] wr_addr;
		logic              wr_valid_en;
		logic              wr_valid;
	} mem_req_t;

endpackage

// ===== hdl/cpts_slot_mem.sv =====
// Task slot storage: one synchronous entry memory plus per-slot valid flops.
// Depends on cpts_pkg. Read data and valid come back one cycle after rd_en.
module cpts_slot_mem (
	input  logic              clk,
	input  logic              arst_n,
	input  cpts_pkg::mem_req_t req,
	input  cpts_pkg::entry_t  wr_data,
	output cpts_pkg::entry_t  rd_data,
	output logic              rd_valid
);

	cpts_pkg::entry_t mem [cpts_pkg::NUM_SLOTS];
	logic [cpts_pkg::NUM_SLOTS-1:0] valid_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= wr_data;
		end
		if (req.rd_en) begin
			rd_data <= mem[req.rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_valid <= 1'b0;
		end else begin
			if (req.wr_valid_en) begin
				valid_q[req.wr_addr] <= req.wr_valid;
			end
			if (req.rd_en) begin
				rd_valid <= valid_q[req.rd_addr];
			end
		end
	end

endmodule

// ===== hdl/counter_priority_task_scheduler.sv =====
// Counter/priority task scheduler. Input channel in_valid/in_ready carries
// either a slot write (op 0) or a schedule request (op 1) with the current
// tick. Output channel out_valid/out_ready returns one result per request:
// a zero acknowledge for a write, or the chosen slot, its counter, the
// recharge flag and the bitmap of woken slots for a schedule request.
// Slot contents live in a single-port-read memory scanned one slot a cycle,
// from the top slot down to slot 1, read-modify-write, with ST_DRAIN and
// ST_DECIDE between passes so a write back never meets a read of the same
// slot. A write goes straight to ST_FIN; a schedule request runs a wake and
// select pass through ST_SCAN, ST_DRAIN and ST_DECIDE, and when all running
// counters are zero a recharge-and-reselect pass follows before ST_FIN.
// One request at a time: the next is accepted the cycle after the result
// register loads. The output register is separate, so a new request is
// accepted while a result still waits for out_ready; a finished request
// holds until the output register frees up. Reset clears all slot valid
// flags (no slot is chosen until written) and empties the pipeline; slot
// data is not cleared.
module counter_priority_task_scheduler (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        op,
	input  logic [5:0]  slot,
	input  logic        slot_valid,
	input  logic [1:0]  run_state,
	input  logic [6:0]  slice_count,
	input  logic [5:0]  prio,
	input  logic [31:0] alarm_at,
	input  logic [31:0] pending_sigs,
	input  logic [31:0] blocked_sigs,
	input  logic [31:0] now_tick,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [5:0]  next_slot,
	output logic [6:0]  best_count,
	output logic        recharged,
	output logic [63:0] woken_mask,
	output logic        is_schedule
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DECIDE,
		ST_FIN
	} state_t;

	state_t state_q;

	logic [cpts_pkg::SLOT_W-1:0] idx_q;
	logic [cpts_pkg::SLOT_W-1:0] idx_s1;
	logic                        issue_s1;
	logic                        pass2_q;
	logic [31:0]                 now_q;
	logic                        found_q;
	logic [6:0]                  best_q;
	logic [cpts_pkg::SLOT_W-1:0] best_idx_q;

	logic [5:0]  res_next_q;
	logic [6:0]  res_count_q;
	logic        res_recharged_q;
	logic [63:0] res_woken_q;
	logic        res_sched_q;

	cpts_pkg::mem_req_t mem_req;
	cpts_pkg::entry_t   wr_data;
	cpts_pkg::entry_t   rd_data;
	logic               rd_valid;

	cpts_pkg::entry_t upd;
	logic             fire;
	logic [31:0]      pend_n;
	logic             wake;
	logic [7:0]       recharge_sum;
	logic             live;
	logic             cand;
	logic             accept;
	logic             wr_ok;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign wr_ok    = ({1'b0, slot} < 7'(cpts_pkg::NUM_SLOTS));

	cpts_slot_mem u_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (mem_req),
		.wr_data  (wr_data),
		.rd_data  (rd_data),
		.rd_valid (rd_valid)
	);

	// slot update for the entry coming out of the memory
	always_comb begin
		fire   = (rd_data.alarm != 32'd0) && (rd_data.alarm < now_q);
		pend_n = rd_data.pending | (fire ? cpts_pkg::SIG_ALARM_BIT : 32'd0);
		wake   = !pass2_q && (rd_data.run_state == cpts_pkg::RS_INTR) &&
			((pend_n & ~(rd_data.blocked & ~cpts_pkg::UNBLOCKABLE)) != 32'd0);
		recharge_sum = {2'b00, rd_data.counter[6:1]} + {2'b00, rd_data.prio};
		upd = rd_data;
		if (pass2_q) begin
			upd.counter = (recharge_sum > {1'b0, cpts_pkg::COUNTER_MAX}) ?
				cpts_pkg::COUNTER_MAX : recharge_sum[6:0];
		end else begin
			upd.pending = pend_n;
			upd.alarm   = fire ? 32'd0 : rd_data.alarm;
			if (wake) begin
				upd.run_state = cpts_pkg::RS_RUN;
			end
		end
		live = issue_s1 && rd_valid;
		cand = live && (upd.run_state == cpts_pkg::RS_RUN) &&
			(!found_q || (upd.counter > best_q));
	end

	always_comb begin
		mem_req = '0;
		wr_data = upd;
		if (state_q == ST_SCAN) begin
			mem_req.rd_en   = 1'b1;
			mem_req.rd_addr = idx_q;
		end
		if (live) begin
			mem_req.wr_en   = 1'b1;
			mem_req.wr_addr = idx_s1;
		end else if (accept && (op == cpts_pkg::OP_WRITE) && wr_ok) begin
			mem_req.wr_en       = 1'b1;
			mem_req.wr_addr     = slot[cpts_pkg::SLOT_W-1:0];
			mem_req.wr_valid_en = 1'b1;
			mem_req.wr_valid    = slot_valid;
			wr_data.run_state   = run_state;
			wr_data.counter     = slice_count;
			wr_data.prio        = prio;
			wr_data.alarm       = alarm_at;
			wr_data.pending     = pending_sigs;
			wr_data.blocked     = blocked_sigs;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			issue_s1        <= 1'b0;
			idx_q           <= '0;
			idx_s1          <= '0;
			pass2_q         <= 1'b0;
			now_q           <= '0;
			found_q         <= 1'b0;
			best_q          <= '0;
			best_idx_q      <= '0;
			res_next_q      <= '0;
			res_count_q     <= '0;
			res_recharged_q <= 1'b0;
			res_woken_q     <= '0;
			res_sched_q     <= 1'b0;
			out_valid       <= 1'b0;
			next_slot       <= '0;
			best_count      <= '0;
			recharged       <= 1'b0;
			woken_mask      <= '0;
			is_schedule     <= 1'b0;
		end else begin
			issue_s1 <= (state_q == ST_SCAN);
			idx_s1   <= idx_q;

			if (cand) begin
				found_q    <= 1'b1;
				best_q     <= upd.counter;
				best_idx_q <= idx_s1;
			end
			if (live && wake) begin
				res_woken_q <= res_woken_q | (64'd1 << idx_s1);
			end

			// in ST_FIN the result register is reloaded below instead
			if (out_valid && out_ready && (state_q != ST_FIN)) begin
				out_valid <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						res_next_q      <= '0;
						res_count_q     <= '0;
						res_recharged_q <= 1'b0;
						res_woken_q     <= '0;
						if (op == cpts_pkg::OP_SCHED) begin
							res_sched_q <= 1'b1;
							now_q       <= now_tick;
							pass2_q     <= 1'b0;
							found_q     <= 1'b0;
							idx_q       <= cpts_pkg::LAST_SLOT;
							state_q     <= ST_SCAN;
						end else begin
							res_sched_q <= 1'b0;
							state_q     <= ST_FIN;
						end
					end
				end
				ST_SCAN: begin
					if (idx_q == cpts_pkg::FIRST_SLOT) begin
						state_q <= ST_DRAIN;
					end else begin
						idx_q <= idx_q - 1'b1;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					if (!pass2_q && found_q && (best_q == 7'd0)) begin
						// every running task is out of slice: recharge and reselect
						pass2_q         <= 1'b1;
						res_recharged_q <= 1'b1;
						found_q         <= 1'b0;
						idx_q           <= cpts_pkg::LAST_SLOT;
						state_q         <= ST_SCAN;
					end else begin
						res_next_q  <= found_q ? 6'(best_idx_q) : 6'd0;
						res_count_q <= found_q ? best_q : 7'd0;
						state_q     <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (!out_valid || out_ready) begin
						out_valid   <= 1'b1;
						next_slot   <= res_next_q;
						best_count  <= res_count_q;
						recharged   <= res_recharged_q;
						woken_mask  <= res_woken_q;
						is_schedule <= res_sched_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef ASSERT_OFF
	// write back and scan read never hit the same slot in one cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		mem_req.wr_en && mem_req.rd_en |-> mem_req.wr_addr != mem_req.rd_addr)
		else $error("slot memory read and write collide");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_schedule |->
			(woken_mask == 64'd0) && (next_slot == 6'd0) && !recharged)
		else $error("write acknowledge carries schedule data");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !woken_mask[0])
		else $error("idle slot reported as woken");

	assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !issue_s1)
		else $error("request accepted while a scan is in flight");

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DECIDE && pass2_q |=> state_q == ST_FIN)
		else $error("more than one recharge in a decision");
`endif

endmodule
